FILE: rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the token scanner modules.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/pl0ts_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// PL/0 token scanner package
// Types, token codes, character classification and keyword tables.
// ------------------------------------------------------------------------
package pl0ts_pkg;

    localparam int MAX_WORD_CHARS = 10;
    localparam int MAX_DIGITS     = 14;
    localparam int WORD_SLOTS     = 10;
    localparam int NUM_KEYWORDS   = 13;

    typedef logic [59:0] t_text;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_COLON,
        MODE_LESS,
        MODE_GREATER,
        MODE_HALT
    } t_scan_mode;

    typedef enum logic [2:0] {
        CLS_KEYWORD  = 3'd0,
        CLS_IDENT    = 3'd1,
        CLS_NUMBER   = 3'd2,
        CLS_OPERATOR = 3'd3,
        CLS_DELIM    = 3'd4,
        CLS_ERROR    = 3'd5
    } t_tok_cls;

    typedef enum logic [2:0] {
        CK_SPACE,
        CK_LETTER,
        CK_DIGIT,
        CK_COLON,
        CK_LESS,
        CK_GREATER,
        CK_SIMPLE,
        CK_UNKNOWN
    } t_char_kind;

    localparam logic [3:0] OP_BECOMES = 4'd0;
    localparam logic [3:0] OP_LT      = 4'd1;
    localparam logic [3:0] OP_LE      = 4'd2;
    localparam logic [3:0] OP_GT      = 4'd3;
    localparam logic [3:0] OP_GE      = 4'd4;
    localparam logic [3:0] OP_PLUS    = 4'd5;
    localparam logic [3:0] OP_MINUS   = 4'd6;
    localparam logic [3:0] OP_TIMES   = 4'd7;
    localparam logic [3:0] OP_SLASH   = 4'd8;
    localparam logic [3:0] OP_HASH    = 4'd9;
    localparam logic [3:0] OP_BANG    = 4'd10;

    localparam logic [3:0] DL_LPAREN = 4'd0;
    localparam logic [3:0] DL_RPAREN = 4'd1;
    localparam logic [3:0] DL_COMMA  = 4'd2;
    localparam logic [3:0] DL_SEMI   = 4'd3;
    localparam logic [3:0] DL_PERIOD = 4'd4;
    localparam logic [3:0] DL_LBRACE = 4'd5;
    localparam logic [3:0] DL_RBRACE = 4'd6;
    localparam logic [3:0] DL_QUOTE  = 4'd7;

    localparam logic [3:0] ER_COLON   = 4'd0;
    localparam logic [3:0] ER_UNKNOWN = 4'd1;

    localparam logic [7:0] CH_EQUALS = 8'h3d;

    typedef struct packed {
        t_char_kind kind;
        t_tok_cls   cls;
        logic [3:0] code;
    } t_char_info;

    typedef struct packed {
        t_tok_cls    cls;
        logic [3:0]  code;
        logic [31:0] value;
        logic        too_long;
        logic [3:0]  len;
        t_text       text;
    } t_token;

    typedef struct packed {
        t_token     first;
        logic       has_second;
        t_tok_cls   second_cls;
        logic [3:0] second_code;
    } t_entry;

    localparam logic [79:0] KW_ASCII [NUM_KEYWORDS] = '{
        "begin", "call", "const", "do", "end", "if", "odd",
        "procedure", "read", "then", "var", "while", "write"
    };

    function automatic t_char_info classify(input logic [7:0] c);
        t_char_info info;
        info.kind = CK_UNKNOWN;
        info.cls  = CLS_ERROR;
        info.code = ER_UNKNOWN;
        if (c inside {8'h20, 8'h09, 8'h0a, 8'h0d}) begin
            info.kind = CK_SPACE;
        end else if (c inside {[8'h61:8'h7a]}) begin
            info.kind = CK_LETTER;
        end else if (c inside {[8'h30:8'h39]}) begin
            info.kind = CK_DIGIT;
        end else begin
            case (c)
                8'h3a: info.kind = CK_COLON;
                8'h3c: info.kind = CK_LESS;
                8'h3e: info.kind = CK_GREATER;
                8'h2b: begin info.kind = CK_SIMPLE; info.cls = CLS_OPERATOR; info.code = OP_PLUS; end
                8'h2d: begin info.kind = CK_SIMPLE; info.cls = CLS_OPERATOR; info.code = OP_MINUS; end
                8'h2a: begin info.kind = CK_SIMPLE; info.cls = CLS_OPERATOR; info.code = OP_TIMES; end
                8'h2f: begin info.kind = CK_SIMPLE; info.cls = CLS_OPERATOR; info.code = OP_SLASH; end
                8'h23: begin info.kind = CK_SIMPLE; info.cls = CLS_OPERATOR; info.code = OP_HASH; end
                8'h21: begin info.kind = CK_SIMPLE; info.cls = CLS_OPERATOR; info.code = OP_BANG; end
                8'h28: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_LPAREN; end
                8'h29: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_RPAREN; end
                8'h2c: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_COMMA; end
                8'h3b: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_SEMI; end
                8'h2e: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_PERIOD; end
                8'h7b: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_LBRACE; end
                8'h7d: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_RBRACE; end
                8'h22: begin info.kind = CK_SIMPLE; info.cls = CLS_DELIM; info.code = DL_QUOTE; end
                default: ;
            endcase
        end
        return info;
    endfunction

    function automatic logic [5:0] char6(input logic [7:0] c);
        logic [5:0] v;
        if (c inside {[8'h61:8'h7a]}) begin
            v = 6'(c - 8'h61);
        end else begin
            v = 6'(c - 8'd22);
        end
        return v;
    endfunction

    function automatic t_token simple_token(input t_tok_cls cls, input logic [3:0] code);
        t_token t;
        t      = '0;
        t.cls  = cls;
        t.code = code;
        return t;
    endfunction

    // Packs a right-justified ASCII keyword as {length, 6-bit text}.
    function automatic logic [63:0] kw_pack(input logic [79:0] s);
        logic [3:0] len;
        t_text      text;
        logic [7:0] b;
        len  = '0;
        text = '0;
        for (int i = 9; i >= 0; i--) begin
            b = s[8*i +: 8];
            if (b != 8'h00) begin
                text = text | (t_text'(char6(b)) << (6 * len));
                len  = len + 4'd1;
            end
        end
        return {len, text};
    endfunction

endpackage

FILE: rtl/pl0ts_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// Scanner front end
// Accepts one character beat a cycle while the queue is not full, runs the
// scan state machine and pushes the tokens a beat completes to the queue.
// ------------------------------------------------------------------------
module pl0ts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_char_code,
    input  logic              i_end_of_text,
    input  logic              i_queue_full,
    output logic              o_push,
    output pl0ts_pkg::t_entry o_entry
);
    import pl0ts_pkg::*;

    t_scan_mode  r_mode,     n_mode;
    t_text       r_word_buf, n_word_buf;
    logic [3:0]  r_word_len, n_word_len;
    logic [31:0] r_acc,      n_acc;
    logic [4:0]  r_digits,   n_digits;

    logic       accept;
    t_char_info info;
    logic       have_first;
    t_token     first;
    logic       run_idle;
    logic       idle_emit;
    t_token     idle_tok;
    t_token     word_tok;
    t_token     num_tok;
    logic       char_is_eq;
    logic       cont_word;
    logic [5:0] c6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_word_buf <= '0;
            r_word_len <= '0;
            r_acc      <= '0;
            r_digits   <= '0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_word_buf <= n_word_buf;
            r_word_len <= n_word_len;
            r_acc      <= n_acc;
            r_digits   <= n_digits;
        end
    end

    always_comb begin
        accept     = i_push && !i_queue_full;
        info       = classify(i_char_code);
        c6         = char6(i_char_code);
        char_is_eq = (i_char_code == CH_EQUALS);
        cont_word  = (info.kind == CK_LETTER) || (info.kind == CK_DIGIT);

        n_mode     = r_mode;
        n_word_buf = r_word_buf;
        n_word_len = r_word_len;
        n_acc      = r_acc;
        n_digits   = r_digits;

        have_first = 1'b0;
        first      = '0;
        run_idle   = 1'b0;
        idle_emit  = 1'b0;
        idle_tok   = '0;

        word_tok      = '0;
        word_tok.cls  = CLS_IDENT;
        word_tok.len  = r_word_len;
        word_tok.text = r_word_buf;

        num_tok          = '0;
        num_tok.cls      = CLS_NUMBER;
        num_tok.value    = r_acc;
        num_tok.too_long = (r_digits > 5'(MAX_DIGITS + 1));

        if (i_end_of_text) begin
            case (r_mode)
                MODE_WORD: begin
                    have_first = 1'b1;
                    first      = word_tok;
                end
                MODE_NUMBER: begin
                    have_first = 1'b1;
                    first      = num_tok;
                end
                MODE_COLON: begin
                    have_first = 1'b1;
                    first      = simple_token(CLS_ERROR, ER_COLON);
                end
                MODE_LESS: begin
                    have_first = 1'b1;
                    first      = simple_token(CLS_OPERATOR, OP_LT);
                end
                MODE_GREATER: begin
                    have_first = 1'b1;
                    first      = simple_token(CLS_OPERATOR, OP_GT);
                end
                default: ;
            endcase
            n_mode     = MODE_IDLE;
            n_word_buf = '0;
            n_word_len = '0;
            n_acc      = '0;
            n_digits   = '0;
        end else begin
            case (r_mode)
                MODE_WORD: begin
                    if (cont_word) begin
                        if (r_word_len < 4'(MAX_WORD_CHARS)) begin
                            for (int i = 0; i < WORD_SLOTS; i++) begin
                                if (r_word_len == 4'(i)) begin
                                    n_word_buf[6*i +: 6] = c6;
                                end
                            end
                            n_word_len = r_word_len + 4'd1;
                        end
                    end else begin
                        have_first = 1'b1;
                        first      = word_tok;
                        run_idle   = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (info.kind == CK_DIGIT) begin
                        n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                              + {28'd0, i_char_code[3:0]};
                        if (r_digits != 5'd31) begin
                            n_digits = r_digits + 5'd1;
                        end
                    end else begin
                        have_first = 1'b1;
                        first      = num_tok;
                        run_idle   = 1'b1;
                    end
                end
                MODE_COLON: begin
                    have_first = 1'b1;
                    if (char_is_eq) begin
                        first  = simple_token(CLS_OPERATOR, OP_BECOMES);
                        n_mode = MODE_IDLE;
                    end else begin
                        first    = simple_token(CLS_ERROR, ER_COLON);
                        run_idle = 1'b1;
                    end
                end
                MODE_LESS: begin
                    have_first = 1'b1;
                    if (char_is_eq) begin
                        first  = simple_token(CLS_OPERATOR, OP_LE);
                        n_mode = MODE_IDLE;
                    end else begin
                        first    = simple_token(CLS_OPERATOR, OP_LT);
                        run_idle = 1'b1;
                    end
                end
                MODE_GREATER: begin
                    have_first = 1'b1;
                    if (char_is_eq) begin
                        first  = simple_token(CLS_OPERATOR, OP_GE);
                        n_mode = MODE_IDLE;
                    end else begin
                        first    = simple_token(CLS_OPERATOR, OP_GT);
                        run_idle = 1'b1;
                    end
                end
                MODE_HALT: ;
                default: run_idle = 1'b1;
            endcase
        end

        if (run_idle) begin
            n_mode = MODE_IDLE;
            case (info.kind)
                CK_LETTER: begin
                    n_word_buf = t_text'(c6);
                    n_word_len = 4'd1;
                    n_mode     = MODE_WORD;
                end
                CK_DIGIT: begin
                    n_acc    = {28'd0, i_char_code[3:0]};
                    n_digits = 5'd1;
                    n_mode   = MODE_NUMBER;
                end
                CK_COLON:   n_mode = MODE_COLON;
                CK_LESS:    n_mode = MODE_LESS;
                CK_GREATER: n_mode = MODE_GREATER;
                CK_SIMPLE: begin
                    idle_emit = 1'b1;
                    idle_tok  = simple_token(info.cls, info.code);
                end
                CK_UNKNOWN: begin
                    idle_emit = 1'b1;
                    idle_tok  = simple_token(CLS_ERROR, ER_UNKNOWN);
                    n_mode    = MODE_HALT;
                end
                default: ;
            endcase
        end

        o_entry = '0;
        if (have_first) begin
            o_entry.first       = first;
            o_entry.has_second  = idle_emit;
            o_entry.second_cls  = idle_tok.cls;
            o_entry.second_code = idle_tok.code;
        end else begin
            o_entry.first = idle_tok;
        end
        o_push = accept && (have_first || idle_emit);
    end

    `ASSERT_IMPLIES(a_halt_is_silent, i_clk, i_rst_n, accept && (r_mode == MODE_HALT) && !i_end_of_text, !o_push)
    `ASSERT_IMPLIES(a_word_len_bound, i_clk, i_rst_n, r_mode == MODE_WORD, (r_word_len != 4'd0) && (r_word_len <= 4'(MAX_WORD_CHARS)))

endmodule

FILE: rtl/pl0ts_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// Token queue
// Short first-in first-out register queue between the scanner front end
// and the token output stage; one entry holds the tokens of one beat.
// ------------------------------------------------------------------------
module pl0ts_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pl0ts_pkg::t_entry i_entry,
    output logic              o_full,
    output logic              o_valid,
    output pl0ts_pkg::t_entry o_head,
    input  logic              i_pop
);
    import pl0ts_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_comb begin
        o_full   = (r_count == CNT_W'(DEPTH));
        o_valid  = (r_count != '0);
        o_head   = r_mem[r_rd_ptr];
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)

endmodule

FILE: rtl/pl0ts_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// Token output stage
// Takes queue entries, resolves keywords and presents one token beat at a
// time from an output register, marking the last token of each input beat.
// ------------------------------------------------------------------------
module pl0ts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  pl0ts_pkg::t_entry i_head,
    output logic              o_head_pop,
    input  logic              i_pop,
    output logic              o_valid,
    output pl0ts_pkg::t_token o_token,
    output logic              o_last
);
    import pl0ts_pkg::*;

    logic       r_valid, n_valid;
    logic       r_last,  n_last;
    logic       r_pend,  n_pend;
    t_token     r_tok,   n_tok;
    t_tok_cls   r_pend_cls,  n_pend_cls;
    logic [3:0] r_pend_code, n_pend_code;

    logic [NUM_KEYWORDS-1:0] kw_hit;
    logic [3:0]              kw_code;
    t_token                  resolved;
    logic                    load;

    for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
        localparam logic [63:0] KW = kw_pack(KW_ASCII[k]);
        assign kw_hit[k] = (i_head.first.len == KW[63:60]) && (i_head.first.text == KW[59:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_last  <= n_last;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok       <= n_tok;
        r_pend_cls  <= n_pend_cls;
        r_pend_code <= n_pend_code;
    end

    always_comb begin
        kw_code = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (kw_hit[k]) begin
                kw_code = 4'(k);
            end
        end
        resolved = i_head.first;
        if ((i_head.first.cls == CLS_IDENT) && (kw_hit != '0)) begin
            resolved.cls  = CLS_KEYWORD;
            resolved.code = kw_code;
        end

        load        = !r_valid || i_pop;
        n_valid     = r_valid;
        n_last      = r_last;
        n_pend      = r_pend;
        n_tok       = r_tok;
        n_pend_cls  = r_pend_cls;
        n_pend_code = r_pend_code;
        o_head_pop  = 1'b0;

        if (load) begin
            if (r_pend) begin
                n_tok   = simple_token(r_pend_cls, r_pend_code);
                n_last  = 1'b1;
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else if (i_head_valid) begin
                n_tok       = resolved;
                n_last      = !i_head.has_second;
                n_pend      = i_head.has_second;
                n_pend_cls  = i_head.second_cls;
                n_pend_code = i_head.second_code;
                n_valid     = 1'b1;
                o_head_pop  = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end

        o_valid = r_valid;
        o_token = r_tok;
        o_last  = r_last;
    end

    `ASSERT_IMPLIES(a_pend_behind_first, i_clk, i_rst_n, r_pend, r_valid && !r_last)
    `ASSERT_IMPLIES(a_pop_only_on_load, i_clk, i_rst_n, o_head_pop, i_head_valid && !r_pend)
    `ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, r_pend && i_pop, r_valid && r_last)

endmodule

FILE: rtl/pl0_token_scanner.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// PL/0 token scanner
// Scans a stream of source characters into PL/0 tokens.
// ------------------------------------------------------------------------
// Input side: one character per beat, taken when push is high and full is
// low; end_of_text in a beat flushes any pending token and returns the
// scanner to idle. Output side: the oldest token stands on the o_ ports
// while empty is low and is taken when pop is high.
// A beat gives zero, one or two tokens; o_last_of_run marks the last token
// that a beat gives. When the output side is free, the first token of a
// beat passes through the queue and then the output register to the ports.
// Throughput: one character beat per cycle while full is low and one token
// beat per cycle while pop is high; the single output register sets the
// token rate, so a beat giving two tokens holds the output register for
// both in turn and the queue of QUEUE_DEPTH entries absorbs the difference.
// If the receiver stalls, tokens wait in the output register and queue;
// full rises once the queue fills and no character is taken until space
// frees. Synchronous reset empties the queue and returns the scanner to
// idle with cleared word and number buffers.
// ------------------------------------------------------------------------
module pl0_token_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_token_class,
    output logic [3:0]  o_token_code,
    output logic [31:0] o_number_value,
    output logic        o_number_too_long,
    output logic [3:0]  o_ident_length,
    output logic [59:0] o_ident_text,
    output logic        o_last_of_run
);
    import pl0ts_pkg::*;

    logic   q_full;
    logic   q_push;
    t_entry q_in;
    logic   q_valid;
    t_entry q_head;
    logic   q_pop;
    logic   out_valid;
    t_token out_tok;

    pl0ts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_char_code  (i_char_code),
        .i_end_of_text(i_end_of_text),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_entry      (q_in)
    );

    pl0ts_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_entry(q_in),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_head (q_head),
        .i_pop  (q_pop)
    );

    pl0ts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(q_valid),
        .i_head      (q_head),
        .o_head_pop  (q_pop),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_token     (out_tok),
        .o_last      (o_last_of_run)
    );

    assign full              = q_full;
    assign empty             = !out_valid;
    assign o_token_class     = out_tok.cls;
    assign o_token_code      = out_tok.code;
    assign o_number_value    = out_tok.value;
    assign o_number_too_long = out_tok.too_long;
    assign o_ident_length    = out_tok.len;
    assign o_ident_text      = out_tok.text;

endmodule
